// ===== hdl/elevation_cell_bilinear_upsampler_macros.svh =====
// Assertion macros for the elevation cell bilinear upsampler.
// Included by the top level; depends on nothing else.
`ifndef ELEVATION_CELL_BILINEAR_UPSAMPLER_MACROS_SVH
`define ELEVATION_CELL_BILINEAR_UPSAMPLER_MACROS_SVH
`ifndef SYNTHESIS
// A condition that must hold at every clock edge outside reset.
`define ECBU_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// A condition that must hold whenever the antecedent holds.
`define ECBU_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ECBU_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ECBU_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/ecbu_pkg.sv =====
// Shared types and constants of the elevation cell bilinear upsampler.
// Used by the front, queue, divider, back end and top level; no dependencies.
package ecbu_pkg;

  // Field widths.
  localparam int CORNER_W = 16;
  localparam int COORD_W  = 12;
  localparam int STEP_W   = 4;
  localparam int SCALE_W  = 16;
  localparam int SIZE_W   = 13;
  localparam int POS_W    = 15;
  localparam int ELEV_W   = 16;
  localparam int DIFF_W   = CORNER_W + 1;
  localparam int FRAC_W   = 16;

  // Stream widths.
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 1;

  // Q16.16 working values and divider sizes.
  localparam int FIX_W        = 34;
  localparam int DIV_W        = 33;
  localparam int MAG_W        = 32;
  localparam int DIV_BITS_CYC = 8;
  localparam int DIV_CYCLES   = MAG_W / DIV_BITS_CYC;
  localparam int DIV_CNT_W    = $clog2(DIV_CYCLES);
  localparam int REM_W        = STEP_W;

  // Scaling: Q16.16 times Q8.8 gives Q24.24.
  localparam int PROD_W     = MAG_W + SCALE_W;
  localparam int ROUND_SHIFT = 24;

  // Default for the largest step count.
  localparam int MAX_STEP_DEF = 8;

  // Queue between front and back end.
  localparam int QUEUE_DEPTH = 2;

  // Configuration port.
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam int APB_W     = 32;
  localparam logic [REG_IDX_W-1:0] REG_ARC_STEP_X   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ARC_STEP_Y   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT_SCALE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OUT_WIDTH    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OUT_DEPTH    = 3'd4;

  // Back-end sequencer states.
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] S_IDLE   = 3'd0;
  localparam logic [ST_W-1:0] S_LDIV   = 3'd1;
  localparam logic [ST_W-1:0] S_RDIV   = 3'd2;
  localparam logic [ST_W-1:0] S_CSTART = 3'd3;
  localparam logic [ST_W-1:0] S_CDIV   = 3'd4;
  localparam logic [ST_W-1:0] S_EMIT   = 3'd5;

  // Configuration as seen by the datapath; step counts already clamped.
  typedef struct packed {
    logic [STEP_W-1:0]  step_x;
    logic [STEP_W-1:0]  step_y;
    logic [SCALE_W-1:0] height_scale;
    logic [SIZE_W-1:0]  out_width;
    logic [SIZE_W-1:0]  out_depth;
  } cfg_t;

  // One classified cell as it waits in the queue.
  typedef struct packed {
    logic [CORNER_W-1:0] corner_a;
    logic [CORNER_W-1:0] corner_b;
    logic [DIFF_W-1:0]   diff_l;
    logic [DIFF_W-1:0]   diff_r;
    logic [POS_W-1:0]    base_x;
    logic [POS_W-1:0]    base_y;
  } cell_t;

endpackage

// ===== hdl/ecbu_front.sv =====
// Front end: accepts cell transactions and turns them into queue entries.
// Depends on ecbu_pkg for the cell and configuration types.
module ecbu_front (
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // Fields from bit 0 up: corner_a, corner_b, corner_c, corner_d, cell_col, cell_row.
  input  logic [ecbu_pkg::IN_TDATA_W-1:0] s_tdata,
  input  ecbu_pkg::cfg_t                  cfg,
  input  logic                            queue_full,
  output logic                            push,
  output ecbu_pkg::cell_t                 entry
);
  import ecbu_pkg::*;

  logic [CORNER_W-1:0]   corner_a;
  logic [CORNER_W-1:0]   corner_b;
  logic [CORNER_W-1:0]   corner_c;
  logic [CORNER_W-1:0]   corner_d;
  logic [COORD_W-1:0]    cell_col;
  logic [COORD_W-1:0]    cell_row;
  logic [POS_W:0]        prod_x;
  logic [POS_W:0]        prod_y;

  // Unpack the input fields.
  assign corner_a = s_tdata[15:0];
  assign corner_b = s_tdata[31:16];
  assign corner_c = s_tdata[47:32];
  assign corner_d = s_tdata[63:48];
  assign cell_col = s_tdata[75:64];
  assign cell_row = s_tdata[87:76];

  // A transaction is taken whenever the queue has room.
  assign s_tready = !queue_full;
  assign push     = s_tvalid && s_tready;

  // Cell origin in output coordinates, kept to the position width.
  assign prod_x = {{(POS_W+1-COORD_W){1'b0}}, cell_col} * {{(POS_W+1-STEP_W){1'b0}}, cfg.step_x};
  assign prod_y = {{(POS_W+1-COORD_W){1'b0}}, cell_row} * {{(POS_W+1-STEP_W){1'b0}}, cfg.step_y};

  // Edge differences feed the row-step divisions in the back end.
  always_comb begin
    entry.corner_a = corner_a;
    entry.corner_b = corner_b;
    entry.diff_l   = {1'b0, corner_c} - {1'b0, corner_a};
    entry.diff_r   = {1'b0, corner_d} - {1'b0, corner_b};
    entry.base_x   = prod_x[POS_W-1:0];
    entry.base_y   = prod_y[POS_W-1:0];
  end

endmodule

// ===== hdl/ecbu_queue.sv =====
// Short queue of classified cells between the front and the back end.
// Depends on ecbu_pkg for the entry type and the depth.
module ecbu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ecbu_pkg::cell_t wr_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output ecbu_pkg::cell_t rd_data
);
  import ecbu_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cell_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== hdl/ecbu_div.sv =====
// Iterative divider of a signed Q16.16 value by a small step count, truncating toward zero.
// Depends on ecbu_pkg for widths; retires eight quotient bits per cycle.
module ecbu_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ecbu_pkg::DIV_W-1:0]    dividend,
  input  logic [ecbu_pkg::STEP_W-1:0]   divisor,
  output logic                          done,
  output logic [ecbu_pkg::DIV_W-1:0]    quotient
);
  import ecbu_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [MAG_W-1:0]     mag;
  logic [REM_W-1:0]     rem;
  logic [STEP_W-1:0]    dvs;
  logic                 neg;
  logic [DIV_W-1:0]     neg_dividend;
  logic [MAG_W-1:0]     mag_next;
  logic [REM_W-1:0]     rem_next;

  assign neg_dividend = DIV_W'(0) - dividend;

  // Eight restoring steps on the narrow remainder.
  always_comb begin
    logic [REM_W:0] r;
    logic [MAG_W-1:0] m;
    r = {1'b0, rem};
    m = mag;
    for (int i = 0; i < DIV_BITS_CYC; i++) begin
      r = {r[REM_W-1:0], m[MAG_W-1]};
      m = {m[MAG_W-2:0], 1'b0};
      if (r >= {1'b0, dvs}) begin
        r    = r - {1'b0, dvs};
        m[0] = 1'b1;
      end
    end
    mag_next = m;
    rem_next = r[REM_W-1:0];
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand and partial quotient registers.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DIV_W-1];
      mag <= dividend[DIV_W-1] ? neg_dividend[MAG_W-1:0] : dividend[MAG_W-1:0];
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      mag <= mag_next;
      rem <= rem_next;
    end
  end

  assign quotient = neg ? (DIV_W'(0) - {1'b0, mag}) : {1'b0, mag};

endmodule

// ===== hdl/ecbu_back.sv =====
// Back end: walks each queued cell row by row and emits scaled points.
// Depends on ecbu_pkg and instantiates the shared step divider ecbu_div.
module ecbu_back #(
  parameter int MAX_STEP = ecbu_pkg::MAX_STEP_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ecbu_pkg::cfg_t                   cfg,
  input  logic                             q_empty,
  input  ecbu_pkg::cell_t                  q_data,
  output logic                             pop,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // Fields from bit 0 up: elevation, pos_x, pos_y, then zero fill.
  output logic [ecbu_pkg::OUT_TDATA_W-1:0] m_tdata,
  // Fields from bit 0 up: in_bounds.
  output logic [ecbu_pkg::OUT_TUSER_W-1:0] m_tuser,
  output logic                             m_tlast
);
  import ecbu_pkg::*;

  localparam int CNT_W = (MAX_STEP > 1) ? $clog2(MAX_STEP) : 1;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             in_bounds;
    logic             last;
  } point_meta_t;

  // Sequencer state and cell walk registers.
  logic [ST_W-1:0]  state;
  logic [FIX_W-1:0] left;
  logic [FIX_W-1:0] right;
  logic [FIX_W-1:0] pt;
  logic [DIV_W-1:0] lstep;
  logic [DIV_W-1:0] rstep;
  logic [DIV_W-1:0] cstep;
  logic [DIFF_W-1:0] diff_r;
  logic [POS_W-1:0] base_x;
  logic [POS_W-1:0] base_y;
  logic [CNT_W-1:0] col;
  logic [CNT_W-1:0] row;

  // Divider hookup.
  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [STEP_W-1:0] div_divisor;
  logic              div_done;
  logic [DIV_W-1:0]  div_quot;

  // Point pipeline: operand stage, product stage, output register.
  logic              s1_valid;
  logic [MAG_W-1:0]  s1_val;
  point_meta_t       s1_meta;
  logic              s2_valid;
  logic [PROD_W-1:0] s2_prod;
  point_meta_t       s2_meta;
  logic [ELEV_W-1:0] elevation;
  point_meta_t       o_meta;

  logic              out_free;
  logic              s2_free;
  logic              s1_free;
  logic              issue;
  logic              col_last;
  logic              row_last;
  logic [FIX_W-1:0]  edge_diff;
  point_meta_t       new_meta;
  logic              pt_pos;
  logic [PROD_W:0]   rounded;
  logic [PROD_W-ROUND_SHIFT:0] shifted;

  ecbu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Pipeline flow control.
  assign out_free = !m_tvalid || m_tready;
  assign s2_free  = !s2_valid || out_free;
  assign s1_free  = !s1_valid || s2_free;
  assign issue    = (state == S_EMIT) && s1_free;

  assign col_last  = (STEP_W'(col) == cfg.step_x - STEP_W'(1));
  assign row_last  = (STEP_W'(row) == cfg.step_y - STEP_W'(1));
  assign edge_diff = right - left;

  // Point coordinates and flags for the point now issued.
  always_comb begin
    new_meta.pos_x     = base_x + POS_W'(col);
    new_meta.pos_y     = base_y + POS_W'(row);
    new_meta.in_bounds = (new_meta.pos_x < POS_W'(cfg.out_width)) &&
                         (new_meta.pos_y < POS_W'(cfg.out_depth));
    new_meta.last      = col_last && row_last;
  end

  assign pt_pos = !pt[FIX_W-1] && (pt != '0);

  // Divider requests: left and right row steps, then one column step per row.
  always_comb begin
    pop          = 1'b0;
    div_start    = 1'b0;
    div_dividend = edge_diff[DIV_W-1:0];
    div_divisor  = cfg.step_x;
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          pop          = 1'b1;
          div_start    = 1'b1;
          div_dividend = {q_data.diff_l, {FRAC_W{1'b0}}};
          div_divisor  = cfg.step_y;
        end
      end
      S_LDIV: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = {diff_r, {FRAC_W{1'b0}}};
          div_divisor  = cfg.step_y;
        end
      end
      S_CSTART: begin
        div_start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            state <= S_LDIV;
          end
        end
        S_LDIV: begin
          if (div_done) begin
            state <= S_RDIV;
          end
        end
        S_RDIV: begin
          if (div_done) begin
            state <= S_CSTART;
          end
        end
        S_CSTART: begin
          state <= S_CDIV;
        end
        S_CDIV: begin
          if (div_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (issue && col_last) begin
            state <= row_last ? S_IDLE : S_CSTART;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Cell walk: edge values, steps and counters.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        left   <= {2'b00, q_data.corner_a, {FRAC_W{1'b0}}};
        right  <= {2'b00, q_data.corner_b, {FRAC_W{1'b0}}};
        diff_r <= q_data.diff_r;
        base_x <= q_data.base_x;
        base_y <= q_data.base_y;
        row    <= '0;
      end
      S_LDIV: begin
        lstep <= div_quot;
      end
      S_RDIV: begin
        rstep <= div_quot;
      end
      S_CDIV: begin
        cstep <= div_quot;
        pt    <= left;
        col   <= '0;
      end
      S_EMIT: begin
        if (issue) begin
          pt <= pt + {cstep[DIV_W-1], cstep};
          if (col_last) begin
            col   <= '0;
            left  <= left + {lstep[DIV_W-1], lstep};
            right <= right + {rstep[DIV_W-1], rstep};
            row   <= row + CNT_W'(1);
          end else begin
            col <= col + CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= issue;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (out_free) begin
        m_tvalid <= s2_valid;
      end
    end
  end

  // Round half up from Q24.24 and saturate to 16 bits.
  assign rounded = {1'b0, s2_prod} + (PROD_W+1)'(1) * (PROD_W+1)'(2 ** (ROUND_SHIFT - 1));
  assign shifted = rounded[PROD_W:ROUND_SHIFT];

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_val  <= pt_pos ? pt[MAG_W-1:0] : '0;
      s1_meta <= new_meta;
    end
    if (s2_free) begin
      s2_prod <= {{(PROD_W-MAG_W){1'b0}}, s1_val} * {{(PROD_W-SCALE_W){1'b0}}, cfg.height_scale};
      s2_meta <= s1_meta;
    end
    if (out_free) begin
      elevation <= (|shifted[PROD_W-ROUND_SHIFT:ELEV_W]) ? {ELEV_W{1'b1}} : shifted[ELEV_W-1:0];
      o_meta    <= s2_meta;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W-ELEV_W-2*POS_W){1'b0}}, o_meta.pos_y, o_meta.pos_x, elevation};
  assign m_tuser = o_meta.in_bounds;
  assign m_tlast = o_meta.last;

endmodule

// ===== hdl/elevation_cell_bilinear_upsampler.sv =====
// Elevation cell bilinear upsampler: one cell in, step_x * step_y points out.
// With the back end idle, the first point of a cell leaves after three step divisions
// and then a three-stage point pipeline.
// The back end walks one cell at a time with the shared step divider and issues
// one point per cycle within a row while the output is not stalled.
// Reset (rst, synchronous): registers return to their defaults, queue and pipeline empty.
`include "elevation_cell_bilinear_upsampler_macros.svh"
module elevation_cell_bilinear_upsampler #(
  parameter int MAX_STEP = ecbu_pkg::MAX_STEP_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Cell input stream.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // Fields from bit 0 up: corner_a, corner_b, corner_c, corner_d, cell_col, cell_row.
  input  logic [ecbu_pkg::IN_TDATA_W-1:0]  s_tdata,
  // Point output stream.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // Fields from bit 0 up: elevation, pos_x, pos_y, then zero fill.
  output logic [ecbu_pkg::OUT_TDATA_W-1:0] m_tdata,
  // Fields from bit 0 up: in_bounds.
  output logic [ecbu_pkg::OUT_TUSER_W-1:0] m_tuser,
  output logic                             m_tlast,
  // Configuration port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ecbu_pkg::ADDR_W-1:0]      paddr,
  input  logic [ecbu_pkg::APB_W-1:0]       pwdata,
  output logic [ecbu_pkg::APB_W-1:0]       prdata,
  output logic                             pready
);
  import ecbu_pkg::*;

  logic [STEP_W-1:0]    arc_step_x;
  logic [STEP_W-1:0]    arc_step_y;
  logic [SCALE_W-1:0]   height_scale;
  logic [SIZE_W-1:0]    out_width;
  logic [SIZE_W-1:0]    out_depth;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  cfg_t                 cfg;
  logic                 queue_full;
  logic                 queue_empty;
  logic                 push;
  logic                 pop;
  cell_t                entry;
  cell_t                head;
  logic [ELEV_W-1:0]    out_elevation;
  logic [POS_W-1:0]     out_pos_x;
  logic [POS_W-1:0]     out_pos_y;
  logic                 pos_inside;
  logic                 flat_point;

  // Register file access.
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      arc_step_x   <= STEP_W'(1);
      arc_step_y   <= STEP_W'(1);
      height_scale <= SCALE_W'(256);
      out_width    <= SIZE_W'(4096);
      out_depth    <= SIZE_W'(4096);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ARC_STEP_X:   arc_step_x   <= pwdata[STEP_W-1:0];
        REG_ARC_STEP_Y:   arc_step_y   <= pwdata[STEP_W-1:0];
        REG_HEIGHT_SCALE: height_scale <= pwdata[SCALE_W-1:0];
        REG_OUT_WIDTH:    out_width    <= pwdata[SIZE_W-1:0];
        REG_OUT_DEPTH:    out_depth    <= pwdata[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (reg_idx)
      REG_ARC_STEP_X:   prdata = APB_W'(arc_step_x);
      REG_ARC_STEP_Y:   prdata = APB_W'(arc_step_y);
      REG_HEIGHT_SCALE: prdata = APB_W'(height_scale);
      REG_OUT_WIDTH:    prdata = APB_W'(out_width);
      REG_OUT_DEPTH:    prdata = APB_W'(out_depth);
      default:          prdata = '0;
    endcase
  end

  // Step counts of zero act as one, counts above the maximum act as the maximum.
  always_comb begin
    cfg.step_x = (arc_step_x == '0) ? STEP_W'(1) :
                 (arc_step_x > STEP_W'(MAX_STEP)) ? STEP_W'(MAX_STEP) : arc_step_x;
    cfg.step_y = (arc_step_y == '0) ? STEP_W'(1) :
                 (arc_step_y > STEP_W'(MAX_STEP)) ? STEP_W'(MAX_STEP) : arc_step_y;
    cfg.height_scale = height_scale;
    cfg.out_width    = out_width;
    cfg.out_depth    = out_depth;
  end

  ecbu_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .cfg        (cfg),
    .queue_full (queue_full),
    .push       (push),
    .entry      (entry)
  );

  ecbu_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (entry),
    .full    (queue_full),
    .pop     (pop),
    .empty   (queue_empty),
    .rd_data (head)
  );

  ecbu_back #(
    .MAX_STEP (MAX_STEP)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (queue_empty),
    .q_data   (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Output fields for the checks below.
  assign out_elevation = m_tdata[ELEV_W-1:0];
  assign out_pos_x     = m_tdata[ELEV_W+POS_W-1:ELEV_W];
  assign out_pos_y     = m_tdata[ELEV_W+2*POS_W-1:ELEV_W+POS_W];
  assign pos_inside    = (out_pos_x < POS_W'(out_width)) && (out_pos_y < POS_W'(out_depth));
  assign flat_point    = m_tvalid && (height_scale == '0);

  // The bounds flag agrees with the coordinates it travels with.
  `ECBU_ASSERT_IMPLY(a_inb_set, clk, rst, m_tvalid && m_tuser[0], pos_inside, "stray in_bounds")
  `ECBU_ASSERT_IMPLY(a_inb_clr, clk, rst, m_tvalid && !m_tuser[0], !pos_inside, "missing in_bounds")
  // A zero height factor flattens every point.
  `ECBU_ASSERT_IMPLY(a_zero_scale, clk, rst, flat_point, out_elevation == '0, "elevation not flat")

endmodule
